// File: rtl/core/clsp_pkg.sv
// ----------------------------------------------------------------------------
// clsp_pkg: shared types and constants of the closed-loop stepper positioner
// Holds the command and event codes, the configuration register indexes,
// the quadrature decode table and the error flag bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package clsp_pkg;

  // Command codes carried in the func field of an input word.
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_GOTO = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;
  localparam logic [1:0] FUNC_HOME = 2'd3;

  // Event codes reported in event_res.
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_AT_TARGET  = 3'd1;
  localparam logic [2:0] EV_MOVING     = 3'd2;
  localparam logic [2:0] EV_CORRECTING = 3'd3;
  localparam logic [2:0] EV_ERR_LARGE  = 3'd4;
  localparam logic [2:0] EV_STOPPED    = 3'd5;
  localparam logic [2:0] EV_HOMED      = 3'd6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LOOP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_HP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_HP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd5;

  localparam int CFG_DATA_W = 24;
  localparam int LIMIT_W    = 16;
  localparam int PERIOD_W   = 24;
  localparam int OUT_POS_W  = 32;
  localparam int TARGET_W   = 31;
  // Wide enough for any position error before it is saturated to the port.
  localparam int SAT_W      = 35;

  // Result of comparing a position error against the configured limits.
  typedef struct packed {
    logic within_tol;
    logic over_max;
    logic positive;
  } err_flags_t;

  // 4x quadrature decode: index is {previous phase, current phase}.
  function automatic logic signed [1:0] quad_delta(input logic [1:0] prev_phase,
                                                   input logic [1:0] cur_phase);
    logic [3:0] idx;
    logic signed [1:0] d;
    idx = {prev_phase, cur_phase};
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/clsp_err_check.sv
// ----------------------------------------------------------------------------
// clsp_err_check: position error classifier
// Takes a signed error and reports whether its magnitude is within the
// tolerance, above the alarm limit, and whether it points forward.
// ----------------------------------------------------------------------------
`default_nettype none

module clsp_err_check
  import clsp_pkg::*;
#(
  parameter int ERR_W = 35
) (
  input  wire logic signed [ERR_W-1:0] err,
  input  wire logic [LIMIT_W-1:0]      tolerance,
  input  wire logic [LIMIT_W-1:0]      max_error,
  output err_flags_t                   flags
);

  logic [ERR_W-1:0] magnitude;

  // The error never reaches the most negative code, so negation is exact.
  assign magnitude        = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign flags.within_tol = magnitude <= ERR_W'(tolerance);
  assign flags.over_max   = magnitude > ERR_W'(max_error);
  assign flags.positive   = !err[ERR_W-1] && (err != '0);

endmodule

`default_nettype wire

// File: rtl/core/closed_loop_stepper_positioner_unit.sv
// ----------------------------------------------------------------------------
// closed_loop_stepper_positioner_unit: STEP/DIR generator with encoder loop
// Decodes quadrature encoder samples, paces STEP toggles from tick words and
// checks the encoder after each move, correcting or alarming as needed.
// ----------------------------------------------------------------------------
// Each input word carries a command (tick, goto, stop or home) together with
// the sampled encoder levels, and produces exactly one result word with the
// STEP and DIR pin levels, the moving flag, an event code, both position
// counters and the saturated position error. A word accepted at a clock edge
// sits in the input register while the update logic works on it, and its
// result is loaded into the output register once that register is empty or
// its word is being taken, and is held there until the receiver takes it.
// The block takes one word per clock for as long as the result side does not
// stall, so the throughput is one word per cycle. The whole controller state
// is updated together with that load, which is what lets a new word enter
// the input register as its predecessor leaves it. When the output register
// holds a result that is stalled, the input register still takes one more
// word, and only then is in_stall raised. Configuration registers are written
// through the plain write port and should only be changed while no word is
// in flight. Half periods and the settle delay count tick words, not clocks.
// ----------------------------------------------------------------------------
`default_nettype none

module closed_loop_stepper_positioner_unit
  import clsp_pkg::*;
#(
  parameter int TIMER_WIDTH    = 24,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write port.
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  // Input channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic signed [TARGET_W-1:0]  target_position,
  input  wire logic                        enc_a,
  input  wire logic                        enc_b,
  // Output channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             step_level,
  output logic                             dir_level,
  output logic                             moving,
  output logic [2:0]                       event_res,
  output logic signed [OUT_POS_W-1:0]      motor_position,
  output logic signed [OUT_POS_W-1:0]      encoder_position,
  output logic signed [OUT_POS_W-1:0]      position_error
);

  localparam int P     = POSITION_WIDTH;
  localparam int T     = TIMER_WIDTH;
  // Errors against four times the encoder count need two extra bits plus sign.
  localparam int E     = POSITION_WIDTH + 3;
  // Half-period error: difference of two position words.
  localparam int H     = POSITION_WIDTH + 1;
  localparam int CMP_W = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;

  // Configuration registers.
  logic                 closed_loop_enable;
  logic [LIMIT_W-1:0]   tolerance_steps;
  logic [LIMIT_W-1:0]   max_error_steps;
  logic [PERIOD_W-1:0]  move_half_period;
  logic [PERIOD_W-1:0]  correction_half_period;
  logic [PERIOD_W-1:0]  settle_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_loop_enable     <= 1'b1;
      tolerance_steps        <= LIMIT_W'(8);
      max_error_steps        <= LIMIT_W'(217);
      move_half_period       <= PERIOD_W'(9328);
      correction_half_period <= PERIOD_W'(50000);
      settle_ticks           <= PERIOD_W'(50000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOSED_LOOP: closed_loop_enable     <= cfg_data[0];
        CFG_TOLERANCE:   tolerance_steps        <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_ERROR:   max_error_steps        <= cfg_data[LIMIT_W-1:0];
        CFG_MOVE_HP:     move_half_period       <= cfg_data[PERIOD_W-1:0];
        CFG_CORR_HP:     correction_half_period <= cfg_data[PERIOD_W-1:0];
        CFG_SETTLE:      settle_ticks           <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The update stage advances whenever the output register
  // is empty or its word is being taken this cycle.
  // --------------------------------------------------------------------------
  logic                       advance;
  logic                       in_fire;
  logic                       s1_valid;
  logic [1:0]                 s1_func;
  logic signed [TARGET_W-1:0] s1_target;
  logic [1:0]                 s1_phase;
  logic                       process;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;
  assign process  = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func   <= func;
      s1_target <= target_position;
      s1_phase  <= {enc_a, enc_b};
    end
  end

  // --------------------------------------------------------------------------
  // Controller state.
  // --------------------------------------------------------------------------
  logic [1:0]          last_phase,     last_phase_next;
  logic signed [P-1:0] quad_count,     quad_count_next;
  logic signed [P-1:0] step_count,     step_count_next;
  logic signed [P-1:0] goal_steps,     goal_steps_next;
  logic signed [P-1:0] goal_position,  goal_position_next;
  logic                in_motion_flag, in_motion_flag_next;
  logic                direction_flag, direction_flag_next;
  logic                pin_high,       pin_high_next;
  logic                settling,       settling_next;
  logic [T-1:0]        settle_count,   settle_count_next;
  logic [T-1:0]        rate_count,     rate_count_next;
  logic                slow_rate,      slow_rate_next;
  logic [2:0]          event_next;

  // The encoder is decoded first; every later term sees the updated count.
  logic signed [P-1:0]   quad_dec;
  logic signed [E-1:0]   quad_x4;
  logic signed [P-1:0]   target_wrapped;

  assign quad_dec       = quad_count + P'(quad_delta(last_phase, s1_phase));
  assign quad_x4        = E'(quad_dec) <<< 2;
  assign target_wrapped = P'(s1_target);

  // Goto error: new target against the encoder (closed loop) or step counter.
  logic signed [E-1:0] goto_err;
  err_flags_t          goto_flags;

  assign goto_err = E'(target_wrapped) -
                    (closed_loop_enable ? quad_x4 : E'(step_count));

  clsp_err_check #(.ERR_W(E)) u_goto_check (
    .err       (goto_err),
    .tolerance (tolerance_steps),
    .max_error (max_error_steps),
    .flags     (goto_flags)
  );

  // Settle check error: held goal against the encoder.
  logic signed [E-1:0] settle_err;
  err_flags_t          settle_flags;

  assign settle_err = E'(goal_position) - quad_x4;

  clsp_err_check #(.ERR_W(E)) u_settle_check (
    .err       (settle_err),
    .tolerance (tolerance_steps),
    .max_error (max_error_steps),
    .flags     (settle_flags)
  );

  // Half-period error: step goal against the step counter.
  logic signed [H-1:0] step_err;
  err_flags_t          step_flags;

  assign step_err = H'(goal_steps) - H'(step_count);

  clsp_err_check #(.ERR_W(H)) u_step_check (
    .err       (step_err),
    .tolerance (tolerance_steps),
    .max_error (max_error_steps),
    .flags     (step_flags)
  );

  // Step-rate divider. A zero half period behaves as one.
  logic [PERIOD_W-1:0] half_period;
  logic [T-1:0]        rate_inc;
  logic                half_event;
  logic                settle_done;

  always_comb begin
    half_period = slow_rate ? correction_half_period : move_half_period;
    if (half_period == '0) begin
      half_period = PERIOD_W'(1);
    end
  end

  assign rate_inc    = rate_count + T'(1);
  assign half_event  = (CMP_W'(rate_inc) >= CMP_W'(half_period)) || (rate_inc == '0);
  assign settle_done = CMP_W'(settle_count) >= CMP_W'(settle_ticks);

  always_comb begin
    last_phase_next     = s1_phase;
    quad_count_next     = quad_dec;
    step_count_next     = step_count;
    goal_steps_next     = goal_steps;
    goal_position_next  = goal_position;
    in_motion_flag_next = in_motion_flag;
    direction_flag_next = direction_flag;
    pin_high_next       = pin_high;
    settling_next       = settling;
    settle_count_next   = settle_count;
    rate_count_next     = rate_count;
    slow_rate_next      = slow_rate;
    event_next          = EV_NONE;

    case (s1_func)
      FUNC_TICK: begin
        if (in_motion_flag) begin
          rate_count_next = rate_inc;
          if (half_event) begin
            rate_count_next = '0;
            if (step_flags.within_tol) begin
              // Move complete: drop STEP and start the settle wait.
              in_motion_flag_next = 1'b0;
              pin_high_next       = 1'b0;
              settling_next       = 1'b1;
              settle_count_next   = '0;
            end else if (!pin_high) begin
              pin_high_next = 1'b1;
            end else begin
              // A step is counted on the falling edge of STEP.
              pin_high_next   = 1'b0;
              step_count_next = direction_flag ? step_count + P'(1)
                                               : step_count - P'(1);
            end
          end
        end else if (settling) begin
          if (settle_done) begin
            settling_next = 1'b0;
            if (!closed_loop_enable || settle_flags.within_tol) begin
              event_next = EV_AT_TARGET;
            end else if (settle_flags.over_max) begin
              in_motion_flag_next = 1'b0;
              event_next          = EV_ERR_LARGE;
            end else begin
              // Resync to the encoder and run a slow correction move.
              step_count_next     = P'(quad_x4);
              goal_steps_next     = goal_position;
              direction_flag_next = settle_flags.positive;
              slow_rate_next      = 1'b1;
              rate_count_next     = '0;
              in_motion_flag_next = 1'b1;
              event_next          = EV_CORRECTING;
            end
          end else begin
            settle_count_next = settle_count + T'(1);
          end
        end
      end
      FUNC_GOTO: begin
        goal_position_next = target_wrapped;
        if (closed_loop_enable) begin
          step_count_next = P'(quad_x4);
        end
        if (goto_flags.within_tol) begin
          event_next = EV_AT_TARGET;
        end else begin
          // The step goal is the new counter plus the error, i.e. the target.
          goal_steps_next     = target_wrapped;
          direction_flag_next = goto_flags.positive;
          slow_rate_next      = 1'b0;
          rate_count_next     = '0;
          settling_next       = 1'b0;
          in_motion_flag_next = 1'b1;
          event_next          = EV_MOVING;
        end
      end
      FUNC_STOP: begin
        in_motion_flag_next = 1'b0;
        settling_next       = 1'b0;
        pin_high_next       = 1'b0;
        event_next          = EV_STOPPED;
      end
      default: begin
        // Home: the encoder phase is kept, everything positional is cleared.
        step_count_next     = '0;
        goal_steps_next     = '0;
        goal_position_next  = '0;
        quad_count_next     = '0;
        in_motion_flag_next = 1'b0;
        settling_next       = 1'b0;
        pin_high_next       = 1'b0;
        event_next          = EV_HOMED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase     <= '0;
      quad_count     <= '0;
      step_count     <= '0;
      goal_steps     <= '0;
      goal_position  <= '0;
      in_motion_flag <= 1'b0;
      direction_flag <= 1'b1;
      pin_high       <= 1'b0;
      settling       <= 1'b0;
      settle_count   <= '0;
      rate_count     <= '0;
      slow_rate      <= 1'b0;
    end else if (process) begin
      last_phase     <= last_phase_next;
      quad_count     <= quad_count_next;
      step_count     <= step_count_next;
      goal_steps     <= goal_steps_next;
      goal_position  <= goal_position_next;
      in_motion_flag <= in_motion_flag_next;
      direction_flag <= direction_flag_next;
      pin_high       <= pin_high_next;
      settling       <= settling_next;
      settle_count   <= settle_count_next;
      rate_count     <= rate_count_next;
      slow_rate      <= slow_rate_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result word: the reported error is the new goal against the new count,
  // saturated to the port width.
  // --------------------------------------------------------------------------
  logic signed [SAT_W-1:0]     perr_wide;
  logic signed [OUT_POS_W-1:0] perr_sat;

  assign perr_wide = SAT_W'(E'(goal_position_next) - (E'(quad_count_next) <<< 2));

  always_comb begin
    if (!perr_wide[SAT_W-1] && (perr_wide[SAT_W-2:OUT_POS_W-1] != '0)) begin
      perr_sat = {1'b0, {(OUT_POS_W-1){1'b1}}};
    end else if (perr_wide[SAT_W-1] && (perr_wide[SAT_W-2:OUT_POS_W-1] != '1)) begin
      perr_sat = {1'b1, {(OUT_POS_W-1){1'b0}}};
    end else begin
      perr_sat = perr_wide[OUT_POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      step_level       <= pin_high_next;
      dir_level        <= direction_flag_next;
      moving           <= in_motion_flag_next;
      event_res        <= event_next;
      motor_position   <= OUT_POS_W'(step_count_next);
      encoder_position <= OUT_POS_W'(quad_count_next);
      position_error   <= perr_sat;
    end
  end

endmodule

`default_nettype wire

// File: dv/closed_loop_stepper_positioner_unit_tb.sv
// ----------------------------------------------------------------------------
// closed_loop_stepper_positioner_unit_tb: self-checking bench for the stepper
// Drives command and encoder words through the valid/stall handshake, predicts
// every result word from its own model of the motion controller, and compares
// each result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module closed_loop_stepper_positioner_unit_tb;
  import clsp_pkg::*;

  // The longest quiet stretch of a correct run is the long receiver hold-off
  // plus a sender gap and the idle time around register writes, so reaching
  // HANG_LIMIT with no word moved on either channel means the block hung.
  localparam int HANG_LIMIT = 4000;
  localparam int PRINT_CAP  = 40;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] func;
  logic signed [TARGET_W-1:0] target_position;
  logic enc_a;
  logic enc_b;
  logic out_valid;
  logic out_stall;
  logic step_level;
  logic dir_level;
  logic moving;
  logic [2:0] event_res;
  logic signed [OUT_POS_W-1:0] motor_position;
  logic signed [OUT_POS_W-1:0] encoder_position;
  logic signed [OUT_POS_W-1:0] position_error;

  closed_loop_stepper_positioner_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .target_position(target_position),
    .enc_a(enc_a),
    .enc_b(enc_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .step_level(step_level),
    .dir_level(dir_level),
    .moving(moving),
    .event_res(event_res),
    .motor_position(motor_position),
    .encoder_position(encoder_position),
    .position_error(position_error)
  );

  always #1 clk = ~clk;

  // One result word as it appears on the output port.
  typedef struct {
    logic        step;
    logic        dir;
    logic        mov;
    logic [2:0]  ev;
    logic [31:0] motor;
    logic [31:0] enc;
    logic [31:0] perr;
  } pin_word_t;

  // The scoreboard carries its own copy of the controller: register settings,
  // encoder decoder, step-rate divider and settle timer. Every accepted input
  // word advances that copy and queues the result word it must produce.
  class stepper_scoreboard;
    bit        loop_closed;
    bit [15:0] tol_steps;
    bit [15:0] alarm_steps;
    bit [23:0] move_hp;
    bit [23:0] corr_hp;
    bit [23:0] settle_len;

    bit [1:0]  prev_phase;
    int        quad_cnt;
    int        step_cnt;
    int        goal_stp;
    int        goal_pos;
    bit        running;
    bit        fwd;
    bit        pin_hi;
    bit        settle_pending;
    bit        slow;
    bit [23:0] settle_cnt;
    bit [23:0] rate_cnt;

    pin_word_t pending[$];
    int        mismatch_count;
    int        results_seen;

    function new();
      loop_closed = 1'b1;
      tol_steps = 16'd8;
      alarm_steps = 16'd217;
      move_hp = 24'd9328;
      corr_hp = 24'd50000;
      settle_len = 24'd50000;
      prev_phase = 2'b00;
      quad_cnt = 0;
      step_cnt = 0;
      goal_stp = 0;
      goal_pos = 0;
      running = 1'b0;
      fwd = 1'b1;
      pin_hi = 1'b0;
      settle_pending = 1'b0;
      slow = 1'b0;
      settle_cnt = '0;
      rate_cnt = '0;
      mismatch_count = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CLOSED_LOOP: loop_closed = val[0];
        CFG_TOLERANCE:   tol_steps = val[15:0];
        CFG_MAX_ERROR:   alarm_steps = val[15:0];
        CFG_MOVE_HP:     move_hp = val;
        CFG_CORR_HP:     corr_hp = val;
        CFG_SETTLE:      settle_len = val;
        default: ;
      endcase
    endfunction

    function longint abs_of(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // Quadrature phases run 00 -> 10 -> 11 -> 01 going forward; the position
    // of a phase in that cycle is {b, a^b}. A two-phase jump counts nothing.
    function int count_change(bit [1:0] was, bit [1:0] cur);
      bit [1:0] d;
      d = {cur[0], cur[1] ^ cur[0]} - {was[0], was[1] ^ was[0]};
      return (d == 2'd1) ? 1 : (d == 2'd3) ? -1 : 0;
    endfunction

    // One divider expiry: either the move is done or STEP toggles, with a
    // step counted on the falling edge.
    function void half_period();
      longint left;
      left = longint'(goal_stp) - longint'(step_cnt);
      if (abs_of(left) <= longint'(tol_steps)) begin
        running = 1'b0;
        pin_hi = 1'b0;
        settle_pending = 1'b1;
        settle_cnt = '0;
      end else if (!pin_hi) begin
        pin_hi = 1'b1;
      end else begin
        pin_hi = 1'b0;
        step_cnt = step_cnt + (fwd ? 1 : -1);
      end
    endfunction

    // Encoder check after the settle wait.
    function logic [2:0] verify_position();
      longint miss;
      if (!loop_closed) return EV_AT_TARGET;
      miss = longint'(goal_pos) - longint'(quad_cnt) * 4;
      if (abs_of(miss) <= longint'(tol_steps)) return EV_AT_TARGET;
      if (abs_of(miss) > longint'(alarm_steps)) begin
        running = 1'b0;
        return EV_ERR_LARGE;
      end
      step_cnt = quad_cnt * 4;
      goal_stp = int'(longint'(step_cnt) + miss);
      fwd = miss > 0;
      slow = 1'b1;
      rate_cnt = '0;
      running = 1'b1;
      return EV_CORRECTING;
    endfunction

    function pin_word_t note_input(logic [1:0] fn, logic signed [TARGET_W-1:0] tgt,
                                   bit [1:0] ph);
      pin_word_t w;
      logic [2:0] ev;
      bit [23:0] hp;
      longint actual;
      longint miss;
      longint perr;
      ev = EV_NONE;
      quad_cnt = quad_cnt + count_change(prev_phase, ph);
      prev_phase = ph;
      case (fn)
        FUNC_TICK: begin
          if (running) begin
            hp = slow ? corr_hp : move_hp;
            if (hp == 0) hp = 24'd1;
            rate_cnt = rate_cnt + 24'd1;
            if (rate_cnt >= hp || rate_cnt == 0) begin
              rate_cnt = '0;
              half_period();
            end
          end else if (settle_pending) begin
            if (settle_cnt >= settle_len) begin
              settle_pending = 1'b0;
              ev = verify_position();
            end else begin
              settle_cnt = settle_cnt + 24'd1;
            end
          end
        end
        FUNC_GOTO: begin
          goal_pos = tgt;
          if (loop_closed) begin
            step_cnt = quad_cnt * 4;
            actual = longint'(quad_cnt) * 4;
          end else begin
            actual = step_cnt;
          end
          miss = longint'(goal_pos) - actual;
          if (abs_of(miss) <= longint'(tol_steps)) begin
            ev = EV_AT_TARGET;
          end else begin
            goal_stp = int'(longint'(step_cnt) + miss);
            fwd = miss > 0;
            slow = 1'b0;
            rate_cnt = '0;
            settle_pending = 1'b0;
            running = 1'b1;
            ev = EV_MOVING;
          end
        end
        FUNC_STOP: begin
          running = 1'b0;
          settle_pending = 1'b0;
          pin_hi = 1'b0;
          ev = EV_STOPPED;
        end
        FUNC_HOME: begin
          step_cnt = 0;
          goal_stp = 0;
          goal_pos = 0;
          quad_cnt = 0;
          running = 1'b0;
          settle_pending = 1'b0;
          pin_hi = 1'b0;
          ev = EV_HOMED;
        end
        default: ;
      endcase
      perr = longint'(goal_pos) - longint'(quad_cnt) * 4;
      if (perr > 64'sd2147483647) perr = 64'sd2147483647;
      if (perr < -64'sd2147483648) perr = -64'sd2147483648;
      w.step = pin_hi;
      w.dir = fwd;
      w.mov = running;
      w.ev = ev;
      w.motor = step_cnt;
      w.enc = quad_cnt;
      w.perr = perr[31:0];
      pending.push_back(w);
      return w;
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("mismatch at result word %0d: %s got %0h, expected %0h",
                 results_seen, field, got, want);
    endtask

    task check_result(pin_word_t got);
      pin_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word, event", got.ev, 0);
      end else begin
        want = pending.pop_front();
        if (got.step !== want.step) report("step_level", got.step, want.step);
        if (got.dir !== want.dir) report("dir_level", got.dir, want.dir);
        if (got.mov !== want.mov) report("moving", got.mov, want.mov);
        if (got.ev !== want.ev) report("event_res", got.ev, want.ev);
        if (got.motor !== want.motor) report("motor_position", got.motor, want.motor);
        if (got.enc !== want.enc) report("encoder_position", got.enc, want.enc);
        if (got.perr !== want.perr) report("position_error", got.perr, want.perr);
      end
      results_seen++;
    endtask
  endclass

  stepper_scoreboard sb;
  pin_word_t last_word;
  int burst_left;
  int idle_cycles;

  // Offer one input word and hold it until the block takes it. The prediction
  // is made at the accepting edge, so the stimulus that follows can look at
  // the controller state that this word left behind.
  task automatic offer(logic [1:0] fn, logic [TARGET_W-1:0] tgt, bit [1:0] ph);
    in_valid <= 1'b1;
    func <= fn;
    target_position <= tgt;
    enc_a <= ph[1];
    enc_b <= ph[0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_word = sb.note_input(fn, tgt, ph);
  endtask

  // Sender pacing: bursts of random length separated by short gaps. Long
  // bursts run the block at full rate, short ones put gaps on every phase of
  // a move.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Registers only change once every result word is out and the two-stage
  // pipeline has drained, so no word in flight sees a half-written setting.
  task automatic program_regs(bit cl, bit [15:0] tol, bit [15:0] mx,
                              bit [23:0] mhp, bit [23:0] chp, bit [23:0] st);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_one(CFG_CLOSED_LOOP, {23'd0, cl});
    write_one(CFG_TOLERANCE, {8'd0, tol});
    write_one(CFG_MAX_ERROR, {8'd0, mx});
    write_one(CFG_MOVE_HP, mhp);
    write_one(CFG_CORR_HP, chp);
    write_one(CFG_SETTLE, st);
    cfg_we <= 1'b0;
  endtask

  // Random motion episodes. Most words are ticks while a move runs, with the
  // encoder trailing the motor by a per-move bias in counts: no bias ends at
  // target, a small one forces a correction, a large one trips the alarm.
  // A new command is issued when the controller is idle, and now and then in
  // the middle of a move. About one word in ten carries a random encoder
  // phase, which includes two-phase jumps.
  task automatic drive_motion(int count);
    int sent;
    int bias;
    int r;
    int aim;
    int base;
    logic [1:0] fn;
    logic [TARGET_W-1:0] tgt;
    bit [1:0] ph;
    bit [1:0] p;
    sent = 0;
    bias = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      fn = FUNC_TICK;
      tgt = TARGET_W'($urandom);
      if ((!sb.running && !sb.settle_pending && r < 80) || r < 3) begin
        base = sb.loop_closed ? sb.quad_cnt * 4 : sb.step_cnt;
        r = $urandom_range(0, 99);
        if (r < 65) begin
          fn = FUNC_GOTO;
          tgt = TARGET_W'(base + $urandom_range(0, 96) - 48);
        end else if (r < 75) begin
          // Right at the edge of the tolerance band.
          fn = FUNC_GOTO;
          tgt = TARGET_W'(base + ($urandom_range(0, 1) ? int'(sb.tol_steps)
                                                       : -int'(sb.tol_steps))
                          + $urandom_range(0, 2) - 1);
        end else if (r < 82) begin
          fn = FUNC_GOTO;
        end else if (r < 91) begin
          fn = FUNC_STOP;
        end else begin
          fn = FUNC_HOME;
        end
        r = $urandom_range(0, 9);
        if (r < 6) bias = 0;
        else if (r < 8) bias = $urandom_range(0, 1) ? $urandom_range(1, 2) : -$urandom_range(1, 2);
        else bias = $urandom_range(0, 1) ? $urandom_range(5, 15) : -$urandom_range(5, 15);
      end
      if ($urandom_range(0, 9) == 0) begin
        ph = 2'($urandom_range(0, 3));
      end else begin
        aim = (sb.step_cnt >>> 2) + bias;
        p = {sb.prev_phase[0], sb.prev_phase[1] ^ sb.prev_phase[0]};
        if (sb.quad_cnt < aim && $urandom_range(0, 1)) p = p + 2'd1;
        else if (sb.quad_cnt > aim && $urandom_range(0, 1)) p = p - 2'd1;
        ph = {p[1] ^ p[0], p[1]};
      end
      offer(fn, tgt, ph);
      // A correction resyncs to the encoder, so it should be allowed to land.
      if (last_word.ev == EV_CORRECTING) bias = 0;
      sent++;
      pace();
    end
  endtask

  initial begin : main_seq
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CLOSED_LOOP;
    cfg_data <= '0;
    in_valid <= 1'b0;
    func <= FUNC_TICK;
    target_position <= '0;
    enc_a <= 1'b0;
    enc_b <= 1'b0;
    burst_left = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words at the reset settings. First the encoder walks forward
    // through all four phases, back one, then jumps two phases at once.
    offer(FUNC_TICK, '0, 2'b00);
    pace();
    offer(FUNC_TICK, 31'h7FFFFFFF, 2'b10);
    pace();
    offer(FUNC_TICK, '0, 2'b11);
    pace();
    offer(FUNC_TICK, '0, 2'b01);
    pace();
    offer(FUNC_TICK, '0, 2'b00);
    pace();
    offer(FUNC_TICK, '0, 2'b01);
    pace();
    offer(FUNC_TICK, '0, 2'b10);
    pace();
    // Goto to the largest target, a tick, then stop mid-move.
    offer(FUNC_GOTO, 31'h3FFFFFFF, 2'b10);
    pace();
    offer(FUNC_TICK, '0, 2'b10);
    pace();
    offer(FUNC_STOP, '0, 2'b10);
    pace();
    // Goto to the most negative target, then home clears everything.
    offer(FUNC_GOTO, 31'h40000000, 2'b11);
    pace();
    offer(FUNC_HOME, '0, 2'b11);
    pace();
    // Goto on the spot and at the tolerance edge, then just outside it.
    offer(FUNC_GOTO, '0, 2'b11);
    pace();
    offer(FUNC_GOTO, 31'd8, 2'b11);
    pace();
    offer(FUNC_GOTO, 31'd9, 2'b11);
    pace();
    // A goto within tolerance leaves the running move as it is.
    offer(FUNC_GOTO, 31'h7FFFFFF8, 2'b11);
    pace();
    offer(FUNC_TICK, '0, 2'b11);
    pace();
    offer(FUNC_STOP, '0, 2'b11);
    pace();

    // Random phases, each under its own register settings.
    program_regs(1'b1, 16'd2, 16'd40, 24'd2, 24'd3, 24'd4);
    drive_motion(260);
    // Zero half period and zero settle delay; no error tolerated at all.
    program_regs(1'b1, 16'd0, 16'd0, 24'd0, 24'd1, 24'd0);
    drive_motion(180);
    // Open loop: every check reports at target.
    program_regs(1'b0, 16'd4, 16'hFFFF, 24'd1, 24'd5, 24'd2);
    drive_motion(180);
    // Widest tolerance: gotos near the current position are already on target.
    program_regs(1'b1, 16'hFFFF, 16'hFFFF, 24'd3, 24'd2, 24'd1);
    drive_motion(100);
    // Longest periods and settle delay.
    program_regs(1'b1, 16'd1, 16'd30, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    drive_motion(80);
    program_regs(1'b1, 16'd6, 16'd100, 24'd3, 24'd2, 24'd8);
    drive_motion(400);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("closed_loop_stepper_positioner_unit_tb: clean");
    end else begin
      $display("closed_loop_stepper_positioner_unit_tb: errors");
    end
    $finish;
  end

  // Receiver: changes its stall pattern after each random span (never, rare,
  // mostly, alternating). Once, after a few hundred results, it holds off for
  // a long stretch so that the output and input registers fill and the block
  // stalls its input while the sender keeps offering words.
  initial begin : stall_pattern
    int mode;
    int span;
    bit held;
    out_stall <= 1'b0;
    mode = 0;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.results_seen >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 150);
      end
      span--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // Every result word taken by the receiver goes to the scoreboard.
  always @(posedge clk) begin : result_monitor
    pin_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.step = step_level;
      got.dir = dir_level;
      got.mov = moving;
      got.ev = event_res;
      got.motor = motor_position;
      got.enc = encoder_position;
      got.perr = position_error;
      sb.check_result(got);
    end
  end

  // Hang detection: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("closed_loop_stepper_positioner_unit_tb: errors");
      $finish;
    end
  end

endmodule

`default_nettype wire
